@@ sv/fixed_priority_interrupt_controller_top_macros.svh @@
// Assertion helpers for the interrupt controller.
`ifndef FIXED_PRIORITY_INTERRUPT_CONTROLLER_TOP_MACROS_SVH
`define FIXED_PRIORITY_INTERRUPT_CONTROLLER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define FPIC_ASSERT_IMPLY(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error(msg);
// Next-cycle implication, disabled while in reset.
`define FPIC_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error(msg);
`else
`define FPIC_ASSERT_IMPLY(label, clk, rst_n, a, b, msg)
`define FPIC_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif

`endif

@@ sv/fpic_pkg.sv @@
package fpic_pkg;

  localparam int NUM_LINES_DEF = 8;
  localparam int MAX_LINES     = 64;
  localparam int IDX_W         = 6;

  // opcode codes
  localparam logic [1:0] OP_RAISE = 2'd0;
  localparam logic [1:0] OP_ACK   = 2'd1;
  localparam logic [1:0] OP_EOI   = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] irq_line;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [2:0] vector;
    logic [7:0] pending_bits;
    logic [7:0] in_service_bits;
  } out_item_t;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] index;
  } grant_t;

  // one-hot to index; zero input gives zero
  function automatic logic [IDX_W-1:0] onehot_to_idx(input logic [MAX_LINES-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_LINES; i++) begin
      if (oh[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ sv/fpic_in_reg.sv @@
module fpic_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  fpic_pkg::in_item_t item,
  output logic              valid,
  output fpic_pkg::in_item_t item_q
);
  import fpic_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
  end

  assign valid  = valid_r;
  assign item_q = item_r;

endmodule

@@ sv/fpic_resolve.sv @@
module fpic_resolve #(
  parameter int NUM_LINES = fpic_pkg::NUM_LINES_DEF
) (
  input  fpic_pkg::in_item_t     item,
  input  logic [NUM_LINES-1:0]   pending,
  input  logic [NUM_LINES-1:0]   in_service,
  input  logic [NUM_LINES-1:0]   mask,
  output logic [NUM_LINES-1:0]   pending_nxt,
  output logic [NUM_LINES-1:0]   in_service_nxt,
  output fpic_pkg::grant_t       grant
);
  import fpic_pkg::*;

  logic [NUM_LINES-1:0] isr_low;   // highest-priority in-service line, one-hot
  logic [NUM_LINES-1:0] above;     // lines with priority above it
  logic [NUM_LINES-1:0] eligible;
  logic [NUM_LINES-1:0] win;
  logic [NUM_LINES-1:0] raise_oh;

  // nothing in service: 0 - 1 wraps to all lines
  assign isr_low  = in_service & (~in_service + NUM_LINES'(1));
  assign above    = isr_low - NUM_LINES'(1);
  assign eligible = pending & ~mask & above;
  assign win      = eligible & (~eligible + NUM_LINES'(1));
  // a line past the top shifts out to zero
  assign raise_oh = NUM_LINES'(1) << item.irq_line;

  always_comb begin
    pending_nxt    = pending;
    in_service_nxt = in_service;
    grant          = '0;
    unique case (item.opcode)
      OP_RAISE: begin
        pending_nxt = pending | raise_oh;
      end
      OP_ACK: begin
        pending_nxt    = pending & ~win;
        in_service_nxt = in_service | win;
        grant.granted  = |win;
        grant.index    = onehot_to_idx(MAX_LINES'(win));
      end
      OP_EOI: begin
        in_service_nxt = in_service & ~isr_low;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/fixed_priority_interrupt_controller_top.sv @@
// Fixed-priority interrupt controller, fully nested mode (line 0 highest).
//
// Input channel: drive in_item (opcode, irq_line) and pulse start. An item
// is taken at every edge where start is high and busy is low; busy is tied
// low, so one item can be issued every cycle, back to back.
// Opcodes: raise marks a line pending, acknowledge grants the best pending
// unmasked line above the current in-service level, end of interrupt
// retires the highest-priority in-service line. Other codes change nothing.
//
// Result channel: out_strobe is high for one cycle with out_item. A taken
// item passes the input register, then the resolve logic into the state
// and result registers. Sustained rate is one item per cycle;
// the pending/in-service update closes in the second stage, so each item
// sees the state left by the one before it. The receiver cannot stall;
// a result not captured in its strobe cycle is gone.
//
// Config: cfg_we with cfg_wdata writes the interrupt mask; write it only
// while no item is in flight. Reset (rst_n low, synchronous) clears the
// pending, in-service and mask registers and drops any item in flight.
`include "fixed_priority_interrupt_controller_top_macros.svh"

module fixed_priority_interrupt_controller_top #(
  parameter int NUM_LINES = fpic_pkg::NUM_LINES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fpic_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output fpic_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import fpic_pkg::*;

  logic                 accept;
  logic                 v_r;
  in_item_t             item_r;
  logic [7:0]           mask_r;
  logic [NUM_LINES-1:0] mask_nl;
  logic [NUM_LINES-1:0] pending_r;
  logic [NUM_LINES-1:0] in_service_r;
  logic [NUM_LINES-1:0] pending_nxt;
  logic [NUM_LINES-1:0] in_service_nxt;
  grant_t               grant;
  logic [MAX_LINES-1:0] mask_wide;
  logic [MAX_LINES-1:0] pend_wide;
  logic [MAX_LINES-1:0] isr_wide;
  logic                 strobe_r;
  out_item_t            out_r;

  // never stalls the issuer
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: capture the item
  fpic_in_reg u_in_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .valid  (v_r),
    .item_q (item_r)
  );

  // mask covers lines 0..7 only; higher lines are never masked
  assign mask_wide = MAX_LINES'(mask_r);
  assign mask_nl   = mask_wide[NUM_LINES-1:0];

  // stage 2: priority resolve against current state
  fpic_resolve #(
    .NUM_LINES (NUM_LINES)
  ) u_resolve (
    .item           (item_r),
    .pending        (pending_r),
    .in_service     (in_service_r),
    .mask           (mask_nl),
    .pending_nxt    (pending_nxt),
    .in_service_nxt (in_service_nxt),
    .grant          (grant)
  );

  assign pend_wide = MAX_LINES'(pending_nxt);
  assign isr_wide  = MAX_LINES'(in_service_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= '0;
      pending_r    <= '0;
      in_service_r <= '0;
      strobe_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_wdata;
      end
      if (v_r) begin
        pending_r    <= pending_nxt;
        in_service_r <= in_service_nxt;
      end
      strobe_r <= v_r;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (v_r) begin
      out_r.granted         <= grant.granted;
      out_r.vector          <= grant.index[2:0];
      out_r.pending_bits    <= pend_wide[7:0];
      out_r.in_service_bits <= isr_wide[7:0];
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = out_r;

  `FPIC_ASSERT_IMPLY(a_latency, clk, rst_n, accept, ##2 out_strobe, "result strobe missing")
  `FPIC_ASSERT_NEXT(a_raise_isr, clk, rst_n, v_r && item_r.opcode == OP_RAISE,
    in_service_r == $past(in_service_r), "raise changed in-service")
  `FPIC_ASSERT_NEXT(a_eoi_pend, clk, rst_n, v_r && item_r.opcode == OP_EOI,
    pending_r == $past(pending_r), "end of interrupt changed pending")

endmodule
